// ----- design/lcf_pkg.sv -----
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared types and constants of the length/checksum framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcf_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 6;

  // checksum base: length, payload and checksum bytes add up to this
  localparam logic [BYTE_W-1:0] CHK_BASE = 8'hFF;

  // input request payload
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              last_in;
  } lcf_in_t;

  // output request payload
  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              last_out;
    logic              truncated;
  } lcf_out_t;

  // framer sequence
  typedef enum logic [2:0] {
    S_COLLECT,
    S_HEADER,
    S_LENGTH,
    S_PAYLOAD,
    S_CHECK
  } lcf_state_t;

  // control from the sequencer to the buffer
  typedef struct packed {
    logic              wr_en;
    logic [BYTE_W-1:0] wr_byte;
    logic              clear;
  } lcf_ctrl_t;

  // status from the buffer to the sequencer
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] checksum;
    logic              overflow;
  } lcf_status_t;

endpackage

// ----- design/length_checksum_framer.sv -----
// ----------------------------------------------------------------------------
// length_checksum_framer
// Collects payload bytes and sends header, length, payload and checksum.
// ----------------------------------------------------------------------------
//
//  channel  | signals                        | moves
//  ---------+--------------------------------+-------------------------------
//  in       | in_valid, in_stall, in_data    | one payload byte, last flag
//  out      | out_valid, out_stall, out_data | one frame byte, last, truncated
//  cfg      | cfg_we, cfg_data               | header byte
//
//  A payload byte is taken whenever in_stall is low. A frame of n stored
//  bytes is sent one byte a cycle while out_stall is low, through the
//  single read port of the payload store; input is stalled while a frame
//  goes out. Reset clears count, sum, overflow flag and header; no
//  clearing pass. A stalled output holds its byte; a checksum byte may
//  wait while the next frame's bytes are already taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_checksum_framer
  import lcf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcf_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lcf_out_t          out_data,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_data
);

  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

  lcf_state_t        state;
  lcf_state_t        state_next;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  ptr_next;
  logic [CNT_W-1:0]  ptr_inc;
  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] rd_data;
  lcf_ctrl_t         ctrl;
  lcf_status_t       status;
  logic              in_acc;
  logic              load;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;

  // header register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= '0;
    end else if (cfg_we) begin
      header_byte <= cfg_data;
    end
  end

  assign in_stall = (state != S_COLLECT);
  assign in_acc   = in_valid && !in_stall;
  assign load     = !out_valid || !out_stall;
  assign ptr_inc  = ptr + CNT_W'(1);

  // payload store; read address runs one step ahead of the pointer
  lcf_buffer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_buffer (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_addr (ptr_next[ADDR_W-1:0]),
    .rd_data (rd_data),
    .status  (status)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_COLLECT: begin
        if (in_acc && in_data.last_in) state_next = S_HEADER;
      end
      S_HEADER: begin
        if (load) state_next = S_LENGTH;
      end
      S_LENGTH: begin
        if (load) state_next = (status.count == '0) ? S_CHECK : S_PAYLOAD;
      end
      S_PAYLOAD: begin
        if (load && (ptr_inc == status.count)) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (load) state_next = S_COLLECT;
      end
      default: state_next = S_COLLECT;
    endcase
  end

  // sequencer outputs
  always_comb begin
    emit         = 1'b0;
    emit_byte    = header_byte;
    emit_last    = 1'b0;
    ptr_next     = ptr;
    ctrl.wr_en   = 1'b0;
    ctrl.wr_byte = in_data.payload_byte;
    ctrl.clear   = 1'b0;
    case (state)
      S_COLLECT: begin
        ctrl.wr_en = in_acc;
        ptr_next   = '0;
      end
      S_HEADER: begin
        emit     = load;
        ptr_next = '0;
      end
      S_LENGTH: begin
        emit      = load;
        emit_byte = {{(BYTE_W-CNT_W){1'b0}}, status.count};
      end
      S_PAYLOAD: begin
        emit      = load;
        emit_byte = rd_data;
        if (load) ptr_next = ptr_inc;
      end
      S_CHECK: begin
        emit       = load;
        emit_byte  = status.checksum;
        emit_last  = 1'b1;
        ctrl.clear = load;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // state and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.frame_byte <= emit_byte;
      out_data.last_out   <= emit_last;
      out_data.truncated  <= status.overflow;
    end
  end

  // checks
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    status.count <= CNT_MAX)
    else $error("byte count beyond capacity");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    status.overflow |-> (status.count == CNT_MAX))
    else $error("overflow flag set with room in the store");

  a_ptr_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAYLOAD) |-> (ptr < status.count))
    else $error("read pointer past stored bytes");

  a_frame_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_HEADER) |-> (status.count != '0))
    else $error("frame started with an empty store");

endmodule

// ----- design/lcf_buffer.sv -----
// ----------------------------------------------------------------------------
// lcf_buffer
// Payload store with byte count, running sum and overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcf_buffer
  import lcf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  lcf_ctrl_t                                         ctrl,
  input  logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] rd_addr,
  output logic [BYTE_W-1:0]                                 rd_data,
  output lcf_status_t                                       status
);

  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [CNT_W-1:0]  count;
  logic [BYTE_W-1:0] sum;
  logic              overflow;
  logic              has_room;
  logic [BYTE_W-1:0] sum_len;

  assign has_room = (count < CNT_MAX);

  // store write and synchronous read
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && has_room) begin
      mem[count[ADDR_W-1:0]] <= ctrl.wr_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // count, sum and overflow
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count    <= '0;
      sum      <= '0;
      overflow <= 1'b0;
    end else if (ctrl.wr_en) begin
      if (has_room) begin
        count <= count + CNT_W'(1);
        sum   <= sum + ctrl.wr_byte;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // sum of the length and payload bytes of the frame so far
  assign sum_len = sum + {{(BYTE_W-CNT_W){1'b0}}, count};

  assign status.count    = count;
  assign status.checksum = CHK_BASE - sum_len;
  assign status.overflow = overflow;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks length_checksum_framer: payload bytes are sent over the input
// channel, and every frame byte that leaves the output channel is compared
// with a local model of the framer. A short directed table covers the reset
// header, field extremes, the sum of 255 and a full buffer. Random frames
// follow, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lcf_pkg::*;

  localparam int unsigned CAP          = 32;
  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RAND_ITEMS   = 170;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // directed table
  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_RUN,
    ROW_HEADER
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [BYTE_W-1:0] value;
    logic              last;
    int unsigned       reps;
    bit                chk_typed;
    logic [BYTE_W-1:0] chk;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 12;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // header still at its reset value, shortest frame
    '{ROW_BYTE,   8'h00, 1'b1, 1,  1'b1, 8'hFE},
    '{ROW_HEADER, 8'hFF, 1'b0, 1,  1'b0, 8'h00},
    '{ROW_BYTE,   8'hFF, 1'b1, 1,  1'b1, 8'hFF},
    // payload sum of 255 takes the plain checksum rule
    '{ROW_BYTE,   8'hF0, 1'b0, 1,  1'b0, 8'h00},
    '{ROW_BYTE,   8'h0F, 1'b1, 1,  1'b1, 8'hFE},
    '{ROW_HEADER, 8'h5A, 1'b0, 1,  1'b0, 8'h00},
    '{ROW_BYTE,   8'hAA, 1'b0, 1,  1'b0, 8'h00},
    '{ROW_BYTE,   8'h55, 1'b1, 1,  1'b0, 8'h00},
    // fill the buffer, then drop a plain byte and the closing byte
    '{ROW_RUN,    8'h01, 1'b0, 31, 1'b0, 8'h00},
    '{ROW_BYTE,   8'h80, 1'b0, 1,  1'b0, 8'h00},
    '{ROW_BYTE,   8'h7F, 1'b0, 1,  1'b0, 8'h00},
    '{ROW_BYTE,   8'h33, 1'b1, 1,  1'b1, 8'h40}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  lcf_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  lcf_out_t          out_data;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_data;

  // framer model state
  logic [BYTE_W-1:0] hdr_now;
  logic [BYTE_W-1:0] held_bytes [CAP];
  int unsigned       held_count;
  logic [BYTE_W-1:0] held_sum;
  logic              dropped_flag;
  lcf_out_t          frame_bytes_due [$];

  int unsigned       idle_pct;
  int unsigned       stall_left;
  int unsigned       err_count;
  int unsigned       cycle_count;
  lcf_out_t          want_byte;

  length_checksum_framer #(
    .MAX_PAYLOAD (CAP)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // queue one expected frame byte
  task automatic push_due(input logic [BYTE_W-1:0] b, input logic last);
    lcf_out_t r;
    r.frame_byte = b;
    r.last_out   = last;
    r.truncated  = dropped_flag;
    frame_bytes_due.push_back(r);
  endtask

  // model of one accepted request: store or drop, emit a frame on last
  task automatic frame_model_take(input lcf_in_t req, input bit chk_typed,
                                  input logic [BYTE_W-1:0] chk_given);
    logic [BYTE_W-1:0] chk;
    if (held_count < CAP) begin
      held_bytes[held_count] = req.payload_byte;
      held_count             = held_count + 1;
      held_sum               = held_sum + req.payload_byte;
    end else begin
      dropped_flag = 1'b1;
    end
    if (req.last_in) begin
      push_due(hdr_now, 1'b0);
      push_due(BYTE_W'(held_count), 1'b0);
      for (int unsigned i = 0; i < held_count; i++) begin
        push_due(held_bytes[i], 1'b0);
      end
      chk = CHK_BASE - (held_sum + BYTE_W'(held_count));
      if (chk_typed) begin
        chk = chk_given;
      end
      push_due(chk, 1'b1);
      held_count   = 0;
      held_sum     = '0;
      dropped_flag = 1'b0;
    end
  endtask

  // one input request, with an optional random gap ahead of it
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input bit chk_typed, input logic [BYTE_W-1:0] chk);
    int unsigned gap;
    lcf_in_t     req;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 16);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    req.payload_byte = b;
    req.last_in      = last;
    in_data          = req;
    in_valid         = 1'b1;
    do @(posedge clk); while (in_stall);
    frame_model_take(req, chk_typed, chk);
  endtask

  // hold input until every expected byte has left, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_header(input logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we   = 1'b0;
    hdr_now  = v;
  endtask

  // receiver stalls in random bursts
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      // no leftover burst once idling is off
      if (idle_pct == 0) begin
        stall_left = 0;
      end
      if (stall_left != 0) begin
        out_stall  = 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall = 1'b0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          stall_left = $urandom_range(1, 16);
        end
      end
    end
  end

  // compare each accepted frame byte with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected frame byte: frame_byte %h last_out %b truncated %b",
               out_data.frame_byte, out_data.last_out, out_data.truncated);
        err_count++;
      end else begin
        want_byte = frame_bytes_due.pop_front();
        if (out_data.frame_byte !== want_byte.frame_byte) begin
          $error("frame_byte: expected %h, got %h",
                 want_byte.frame_byte, out_data.frame_byte);
          err_count++;
        end
        if (out_data.last_out !== want_byte.last_out) begin
          $error("last_out: expected %b, got %b",
                 want_byte.last_out, out_data.last_out);
          err_count++;
        end
        if (out_data.truncated !== want_byte.truncated) begin
          $error("truncated: expected %b, got %b",
                 want_byte.truncated, out_data.truncated);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned rand_items;
    int unsigned phase_items;
    int unsigned phase;
    int unsigned len;
    bit          paused;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    hdr_now      = '0;
    held_count   = 0;
    held_sum     = '0;
    dropped_flag = 1'b0;
    idle_pct     = 0;
    err_count    = 0;
    cycle_count  = 0;
    rand_items   = 0;
    phase        = 0;
    paused       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    idle_pct = 25;
    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_HEADER: begin
          drain_results();
          set_header(dir_rows[r].value);
        end
        ROW_RUN: begin
          repeat (dir_rows[r].reps) send_byte(dir_rows[r].value, dir_rows[r].last, 1'b0, '0);
        end
        default: begin
          send_byte(dir_rows[r].value, dir_rows[r].last,
                    dir_rows[r].chk_typed, dir_rows[r].chk);
        end
      endcase
    end

    // random frames, a new header per phase
    while (rand_items < RAND_ITEMS) begin
      drain_results();
      case (phase % 4)
        0:       set_header(8'h00);
        1:       set_header(8'hFF);
        default: set_header(BYTE_W'($urandom_range(0, 255)));
      endcase
      // one phase without idling, and none near the end
      idle_pct    = (phase == 2 || rand_items + 40 >= RAND_ITEMS) ? 0 : 30;
      phase_items = 0;
      while (phase_items < 40 && rand_items < RAND_ITEMS) begin
        // mostly short frames, some long, some past the buffer size
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(CAP + 1, CAP + 8);
          1, 2:    len = $urandom_range(7, CAP);
          default: len = $urandom_range(1, 6);
        endcase
        for (int unsigned k = 0; k < len; k++) begin
          send_byte(BYTE_W'($urandom_range(0, 255)), k == len - 1, 1'b0, '0);
        end
        phase_items += len;
        rand_items  += len;
        // sender waits once for all outstanding bytes mid-phase
        if (phase == 1 && !paused && phase_items >= 20) begin
          drain_results();
          paused = 1'b1;
        end
      end
      phase++;
    end

    drain_results();
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- length_checksum_framer.f -----
design/lcf_pkg.sv
design/lcf_buffer.sv
design/length_checksum_framer.sv
tb/tb_top.sv
